>>> hw/rtl/three_channel_root_counter_unit_assert.svh
// ----------------------------------------------------------------------------
// Root counter assertion macros
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_ROOT_COUNTER_UNIT_ASSERT_SVH
`define THREE_CHANNEL_ROOT_COUNTER_UNIT_ASSERT_SVH

// property holds in the same cycle
`define TCRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tcrc_pkg.sv
// ----------------------------------------------------------------------------
// Root counter package
// Types, register map codes, mode bit positions and the IRQ fire helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcrc_pkg;

   localparam int UNITS  = 3;
   localparam int UNIT_W = 2;

   // opcodes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;

   // register select, low nibble of the offset
   localparam logic [3:0] REG_VALUE  = 4'h0;
   localparam logic [3:0] REG_MODE   = 4'h4;
   localparam logic [3:0] REG_TARGET = 4'h8;

   // mode bit positions
   localparam int MB_SYNC_EN    = 0;
   localparam int MB_RST_TARGET = 3;
   localparam int MB_IRQ_TARGET = 4;
   localparam int MB_IRQ_OVF    = 5;
   localparam int MB_REPEAT     = 6;
   localparam int MB_TOGGLE     = 7;
   localparam int MB_IRQ_STAT   = 10;
   localparam int MB_TGT_HIT    = 11;
   localparam int MB_OVF_HIT    = 12;

   localparam logic [12:0] MODE_KEEP   = 13'h1FFF;
   localparam logic [12:0] MODE_STICKY = 13'h1800;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   // sync modes
   localparam logic [1:0] SM_PAUSE = 2'd0;
   localparam logic [1:0] SM_FREE  = 2'd1;
   localparam logic [1:0] SM_GATE  = 2'd2;
   localparam logic [1:0] SM_LATCH = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_SOURCE,
      ST_COUNT,
      ST_EDGE
   } state_type;

   typedef struct packed {
      logic [12:0] mode;
      logic        fired;
      logic        hit;
   } fire_type;

   function automatic fire_type fire(input logic [12:0] mode, input logic fired);
      fire_type r;
      r.mode  = mode;
      r.fired = fired;
      r.hit   = 1'b0;
      if (mode[MB_REPEAT] || !fired) begin
         if (mode[MB_TOGGLE]) begin
            r.mode[MB_IRQ_STAT] = ~mode[MB_IRQ_STAT];
            if (!r.mode[MB_IRQ_STAT]) begin
               r.fired = 1'b1;
               r.hit   = 1'b1;
            end
         end else begin
            r.mode[MB_IRQ_STAT] = 1'b1;
            r.fired = 1'b1;
            r.hit   = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/three_channel_root_counter_unit.sv
// ----------------------------------------------------------------------------
// Three channel root counter unit
// Three 16-bit timers with value, mode and target registers, advanced by
// time step commands one tick per clock through a shared tick unit.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a rising edge with start high and busy low. The
//   opcode picks a register read, a register write or a time step; offset
//   bits 5..4 select the timer and the low nibble the register.
//   Every command returns one result: rsp_valid is high for one cycle with
//   rsp_read_data and rsp_irq_mask. The receiver cannot stall; the result
//   must be taken in that cycle.
//   Reads and writes: busy in the access state, result registered from it.
//   Time steps: the timers are processed one after another by a single
//   tick incrementer, one tick per clock. Each timer passes through source
//   select, a count step for each of its ticks_n ticks plus one exit check,
//   and sync edge, with ticks_n saturated at MAX_TICKS; the result is
//   registered out of the last timer's sync edge. The next command can be
//   taken in the result cycle. Synchronous reset clears all timer state
//   and returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_channel_root_counter_unit #(
   parameter int MAX_TICKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_offset,
   input  logic [15:0] req_write_data,
   input  logic [10:0] req_sys_cycles,
   input  logic [10:0] req_dot_ticks,
   input  logic [10:0] req_hblank_ticks,
   input  logic        req_hblank_now,
   input  logic        req_vblank_edge,
   input  logic        req_vblank_now,
   output logic        rsp_valid,
   output logic [15:0] rsp_read_data,
   output logic [2:0]  rsp_irq_mask
);

`include "three_channel_root_counter_unit_assert.svh"

   localparam int TW   = $clog2(MAX_TICKS + 1);
   localparam int CMPW = (TW > 11) ? TW : 11;
   localparam int UW   = tcrc_pkg::UNIT_W;
   localparam int UN   = tcrc_pkg::UNITS;

   // timer state
   logic [15:0] count_ff  [UN];
   logic [12:0] mode_ff   [UN];
   logic [15:0] target_ff [UN];
   logic [2:0]  rem_ff    [UN];
   logic        fired_ff  [UN];
   logic        begun_ff  [UN];
   logic        rnt_ff    [UN];

   // command capture
   logic [1:0]  op_ff;
   logic [3:0]  reg_ff;
   logic [15:0] wdata_ff;
   logic [10:0] sys_ff, dot_ff, hbl_ff;
   logic        hnow_ff, vedge_ff, vnow_ff;

   tcrc_pkg::state_type state_ff, state_in;
   logic [UW-1:0] unit_ff, unit_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [2:0]    irq_ff, irq_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_irq_ff;

   // next values for the selected timer
   logic        we;
   logic [15:0] u_count_in;
   logic [12:0] u_mode_in;
   logic [15:0] u_target_in;
   logic [2:0]  u_rem_in;
   logic        u_fired_in, u_begun_in, u_rnt_in;

   logic        unit_ok;
   logic [15:0] cur_count, cur_target;
   logic [12:0] cur_mode;
   logic [2:0]  cur_rem;
   logic        cur_fired, cur_begun, cur_rnt;

   logic            accept;
   logic [11:0]     div_total;
   logic [10:0]     src_ticks;
   logic [CMPW-1:0] t_ext, t_sat;
   logic [1:0]      sm;
   logic            in_period, sync_edge_hit;
   logic [15:0]     cnt_next;
   logic [12:0]     m_work;
   logic            f_work, hit;
   tcrc_pkg::fire_type fr_tgt, fr_ovf;

   assign accept  = start && (state_ff == tcrc_pkg::ST_IDLE);
   assign busy    = (state_ff != tcrc_pkg::ST_IDLE);
   assign unit_ok = (unit_ff < UW'(UN));

   assign cur_count  = count_ff[unit_ff];
   assign cur_mode   = mode_ff[unit_ff];
   assign cur_target = target_ff[unit_ff];
   assign cur_rem    = rem_ff[unit_ff];
   assign cur_fired  = fired_ff[unit_ff];
   assign cur_begun  = begun_ff[unit_ff];
   assign cur_rnt    = rnt_ff[unit_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcrc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_opcode == tcrc_pkg::OP_STEP) ? tcrc_pkg::ST_SOURCE
                                                            : tcrc_pkg::ST_ACCESS;
            end
         end
         tcrc_pkg::ST_ACCESS: state_in = tcrc_pkg::ST_IDLE;
         tcrc_pkg::ST_SOURCE: state_in = tcrc_pkg::ST_COUNT;
         tcrc_pkg::ST_COUNT: begin
            if (tick_ff == '0) state_in = tcrc_pkg::ST_EDGE;
         end
         tcrc_pkg::ST_EDGE: begin
            state_in = (unit_ff == UW'(UN - 1)) ? tcrc_pkg::ST_IDLE : tcrc_pkg::ST_SOURCE;
         end
         default: state_in = tcrc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      we           = 1'b0;
      u_count_in   = cur_count;
      u_mode_in    = cur_mode;
      u_target_in  = cur_target;
      u_rem_in     = cur_rem;
      u_fired_in   = cur_fired;
      u_begun_in   = cur_begun;
      u_rnt_in     = cur_rnt;
      unit_in      = unit_ff;
      tick_in      = tick_ff;
      irq_in       = irq_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      div_total    = {1'b0, cur_rem} + {1'b0, sys_ff};
      src_ticks    = sys_ff;
      t_ext        = '0;
      t_sat        = '0;
      sm           = cur_mode[2:1];
      in_period    = (unit_ff == '0) ? hnow_ff : vnow_ff;
      sync_edge_hit = (unit_ff == '0) ? (hbl_ff != '0) : vedge_ff;
      cnt_next     = cur_count + 16'd1;
      m_work       = cur_mode;
      f_work       = cur_fired;
      hit          = 1'b0;
      fr_tgt       = '0;
      fr_ovf       = '0;

      unique case (state_ff)
         tcrc_pkg::ST_IDLE: begin
            if (start) begin
               unit_in = (req_opcode == tcrc_pkg::OP_STEP) ? '0 : req_offset[5:4];
               irq_in  = '0;
            end
         end

         tcrc_pkg::ST_ACCESS: begin
            rsp_valid_in = 1'b1;
            if (unit_ok) begin
               unique case (op_ff)
                  tcrc_pkg::OP_READ: begin
                     unique case (reg_ff)
                        tcrc_pkg::REG_VALUE: rsp_data_in = cur_count;
                        tcrc_pkg::REG_MODE: begin
                           rsp_data_in = {3'b000, cur_mode};
                           u_mode_in   = cur_mode & ~tcrc_pkg::MODE_STICKY;
                           we          = 1'b1;
                        end
                        tcrc_pkg::REG_TARGET: rsp_data_in = cur_target;
                        default: ;
                     endcase
                  end
                  tcrc_pkg::OP_WRITE: begin
                     unique case (reg_ff)
                        tcrc_pkg::REG_VALUE: begin
                           u_count_in = wdata_ff;
                           u_rem_in   = '0;
                           we         = 1'b1;
                        end
                        tcrc_pkg::REG_MODE: begin
                           u_count_in = '0;
                           u_rem_in   = '0;
                           u_fired_in = 1'b0;
                           u_begun_in = 1'b0;
                           u_rnt_in   = 1'b0;
                           u_mode_in  = (wdata_ff[12:0] & tcrc_pkg::MODE_KEEP
                                         & ~tcrc_pkg::MODE_STICKY)
                                        | (13'd1 << tcrc_pkg::MB_IRQ_STAT);
                           we         = 1'b1;
                        end
                        tcrc_pkg::REG_TARGET: begin
                           u_target_in = wdata_ff;
                           we          = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end

         tcrc_pkg::ST_SOURCE: begin
            we = 1'b1;
            if (unit_ff == UW'(0) && cur_mode[8]) begin
               src_ticks = dot_ff;
            end else if (unit_ff == UW'(1) && cur_mode[8]) begin
               src_ticks = hbl_ff;
            end else if (unit_ff == UW'(2) && cur_mode[9]) begin
               // divide by eight, carry the remainder to the next step
               src_ticks = 11'(div_total >> 3);
               u_rem_in  = div_total[2:0];
            end else begin
               src_ticks = sys_ff;
               u_rem_in  = '0;
            end
            if (cur_mode[tcrc_pkg::MB_SYNC_EN]) begin
               if (unit_ff == UW'(2)) begin
                  if (sm == tcrc_pkg::SM_PAUSE || sm == tcrc_pkg::SM_LATCH) src_ticks = '0;
               end else begin
                  unique case (sm)
                     tcrc_pkg::SM_PAUSE: if (in_period) src_ticks = '0;
                     tcrc_pkg::SM_FREE:  ;
                     tcrc_pkg::SM_GATE:  if (!in_period) src_ticks = '0;
                     tcrc_pkg::SM_LATCH: if (!cur_begun) src_ticks = '0;
                     default: ;
                  endcase
               end
            end
            t_ext   = CMPW'(src_ticks);
            t_sat   = (t_ext > CMPW'(MAX_TICKS)) ? CMPW'(MAX_TICKS) : t_ext;
            tick_in = TW'(t_sat);
         end

         tcrc_pkg::ST_COUNT: begin
            if (tick_ff != '0) begin
               we      = 1'b1;
               tick_in = tick_ff - TW'(1);
               if (cur_rnt) begin
                  u_count_in = '0;
                  u_rnt_in   = 1'b0;
               end else begin
                  u_count_in = cnt_next;
                  if (cnt_next == cur_target) begin
                     m_work[tcrc_pkg::MB_TGT_HIT] = 1'b1;
                     if (m_work[tcrc_pkg::MB_IRQ_TARGET]) begin
                        fr_tgt = tcrc_pkg::fire(m_work, f_work);
                        m_work = fr_tgt.mode;
                        f_work = fr_tgt.fired;
                        hit    = fr_tgt.hit;
                     end
                     if (m_work[tcrc_pkg::MB_RST_TARGET]) u_rnt_in = 1'b1;
                  end
                  // wrap can coincide with a target of zero: second fire sees the first
                  if (cur_count == tcrc_pkg::COUNT_MAX) begin
                     m_work[tcrc_pkg::MB_OVF_HIT] = 1'b1;
                     if (m_work[tcrc_pkg::MB_IRQ_OVF]) begin
                        fr_ovf = tcrc_pkg::fire(m_work, f_work);
                        m_work = fr_ovf.mode;
                        f_work = fr_ovf.fired;
                        hit    = hit | fr_ovf.hit;
                     end
                  end
                  u_mode_in  = m_work;
                  u_fired_in = f_work;
               end
               if (hit) irq_in = irq_ff | (3'd1 << unit_ff);
            end
         end

         tcrc_pkg::ST_EDGE: begin
            if (cur_mode[tcrc_pkg::MB_SYNC_EN] && unit_ff != UW'(2) && sync_edge_hit) begin
               we = 1'b1;
               if (sm == tcrc_pkg::SM_FREE || sm == tcrc_pkg::SM_GATE) begin
                  u_count_in = '0;
                  u_rnt_in   = 1'b0;
               end else if (sm == tcrc_pkg::SM_LATCH) begin
                  u_begun_in = 1'b1;
               end
            end
            unit_in = unit_ff + UW'(1);
            if (unit_ff == UW'(UN - 1)) rsp_valid_in = 1'b1;
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcrc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         unit_ff      <= '0;
         tick_ff      <= '0;
         irq_ff       <= '0;
         for (int i = 0; i < UN; i++) begin
            count_ff[i]  <= '0;
            mode_ff[i]   <= '0;
            target_ff[i] <= '0;
            rem_ff[i]    <= '0;
            fired_ff[i]  <= 1'b0;
            begun_ff[i]  <= 1'b0;
            rnt_ff[i]    <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         unit_ff      <= unit_in;
         tick_ff      <= tick_in;
         irq_ff       <= irq_in;
         if (we && unit_ok) begin
            count_ff[unit_ff]  <= u_count_in;
            mode_ff[unit_ff]   <= u_mode_in;
            target_ff[unit_ff] <= u_target_in;
            rem_ff[unit_ff]    <= u_rem_in;
            fired_ff[unit_ff]  <= u_fired_in;
            begun_ff[unit_ff]  <= u_begun_in;
            rnt_ff[unit_ff]    <= u_rnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         reg_ff   <= req_offset[3:0];
         wdata_ff <= req_write_data;
         sys_ff   <= req_sys_cycles;
         dot_ff   <= req_dot_ticks;
         hbl_ff   <= req_hblank_ticks;
         hnow_ff  <= req_hblank_now;
         vedge_ff <= req_vblank_edge;
         vnow_ff  <= req_vblank_now;
      end
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= irq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_irq_mask  = rsp_irq_ff;

   `TCRC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "transfer did not raise busy")
   `TCRC_ASSERT(a_rsp_after_busy, clock, reset, !rsp_valid || $past(busy), "result without command")
   `TCRC_ASSERT(a_tick_bound, clock, reset, tick_ff <= TW'(MAX_TICKS), "tick count above saturation")
   `TCRC_ASSERT(a_irq_only_step, clock, reset, !(rsp_valid && rsp_irq_mask != '0) || $past(state_ff == tcrc_pkg::ST_EDGE), "irq mask on register access")

endmodule
